// ----- rtl/core/ptt_pkg.sv -----
`timescale 1ns / 1ps

package ptt_pkg;

   localparam int unsigned ENTRIES_DEF = 16;

   localparam int unsigned TICK_W  = 32;
   localparam int unsigned CMD_W   = 2;
   localparam int unsigned USED_W  = 5;
   localparam int unsigned ERR_W   = 2;
   localparam int unsigned REQ_W   = 40;
   localparam int unsigned RSP_W   = 8;
   // table word: expired flag, last restart, period
   localparam int unsigned WORD_W  = 2 * TICK_W + 1;

   localparam logic [CMD_W-1:0] OP_TICK  = 2'd0;
   localparam logic [CMD_W-1:0] OP_SCAN  = 2'd1;
   localparam logic [CMD_W-1:0] OP_CHECK = 2'd2;
   localparam logic [CMD_W-1:0] OP_NOP   = 2'd3;

   localparam int unsigned ERR_INVALID = 0;
   localparam int unsigned ERR_FULL    = 1;

   localparam logic [TICK_W-1:0] PERIOD_ZERO = '0;
   localparam logic [TICK_W-1:0] PERIOD_ONES = '1;

   typedef struct packed {
      logic accept;
      logic tick;
      logic set_invalid;
      logic walk_start;
      logic walk;
      logic place;
      logic load_out;
   } ptt_cmd_type;

   typedef struct packed {
      logic [CMD_W-1:0] op;
      logic             period_bad;
      logic             walk_done;
      logic             out_free;
   } ptt_sts_type;

endpackage

// ----- rtl/core/periodic_timer_table.sv -----
`timescale 1ns / 1ps
// channel   direction  ports                       tdata fields (lsb first)
// req       in         req_tvalid/tready/tdata     cmd[1:0], period[33:2], zero pad
// rsp       out        rsp_tvalid/tready/tdata     expired[0], used_count[5:1], error_bits[7:6]
//
// one request at a time; tick, no-op and a bad check period skip the table walk
// scan walks every used entry, check walks entries until a period match, as the
// table memory is read one entry a cycle through its single read port
// synchronous reset clears time, fill count and errors; no table clearing pass,
// entries at or beyond the fill count are never read
// the next request is taken while a response waits in the output register

module periodic_timer_table #(
   parameter int unsigned ENTRIES = ptt_pkg::ENTRIES_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [ptt_pkg::REQ_W-1:0] req_tdata,  // cmd, period, zero pad
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [ptt_pkg::RSP_W-1:0] rsp_tdata   // expired, used_count, error_bits
);

   ptt_pkg::ptt_cmd_type cmd;
   ptt_pkg::ptt_sts_type sts;

   ptt_ctrl u_ptt_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   ptt_datapath #(
      .ENTRIES (ENTRIES)
   ) u_ptt_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .cmd        (cmd),
      .sts        (sts)
   );

endmodule

// ----- rtl/core/ptt_ram.sv -----
`timescale 1ns / 1ps

module ptt_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/ptt_ctrl.sv -----
`timescale 1ns / 1ps

module ptt_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  ptt_pkg::ptt_sts_type sts,
   output ptt_pkg::ptt_cmd_type cmd
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_DECODE = 3'd1;
   localparam logic [2:0] ST_WALK   = 3'd2;
   localparam logic [2:0] ST_PLACE  = 3'd3;
   localparam logic [2:0] ST_DONE   = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               state_in   = ST_DECODE;
            end
         end
         ST_DECODE: begin
            case (sts.op)
               ptt_pkg::OP_TICK: begin
                  cmd.tick = 1'b1;
                  state_in = ST_DONE;
               end
               ptt_pkg::OP_SCAN: begin
                  cmd.walk_start = 1'b1;
                  state_in       = ST_WALK;
               end
               ptt_pkg::OP_CHECK: begin
                  if (sts.period_bad) begin
                     cmd.set_invalid = 1'b1;
                     state_in        = ST_DONE;
                  end else begin
                     cmd.walk_start = 1'b1;
                     state_in       = ST_WALK;
                  end
               end
               default: begin
                  state_in = ST_DONE;
               end
            endcase
         end
         ST_WALK: begin
            cmd.walk = 1'b1;
            if (sts.walk_done) begin
               state_in = (sts.op == ptt_pkg::OP_CHECK) ? ST_PLACE : ST_DONE;
            end
         end
         ST_PLACE: begin
            cmd.place = 1'b1;
            state_in  = ST_DONE;
         end
         ST_DONE: begin
            if (sts.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- rtl/core/ptt_datapath.sv -----
`timescale 1ns / 1ps

module ptt_datapath #(
   parameter int unsigned ENTRIES = ptt_pkg::ENTRIES_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [ptt_pkg::REQ_W-1:0]   req_tdata,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [ptt_pkg::RSP_W-1:0]   rsp_tdata,
   input  ptt_pkg::ptt_cmd_type        cmd,
   output ptt_pkg::ptt_sts_type        sts
);

   localparam int unsigned AW  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int unsigned CW  = $clog2(ENTRIES + 1);
   localparam int unsigned TW  = ptt_pkg::TICK_W;

   logic [TW-1:0]                now_ff, now_in;
   logic [CW-1:0]                count_ff, count_in;
   logic [ptt_pkg::ERR_W-1:0]    err_ff, err_in;
   logic [ptt_pkg::CMD_W-1:0]    op_ff;
   logic [TW-1:0]                per_ff;
   logic [CW-1:0]                iss_ff, iss_in;
   logic                         ev_vld_ff, ev_vld_in;
   logic [AW-1:0]                ev_idx_ff;
   logic                         hit_ff, hit_in;
   logic                         hit_flag_ff, hit_flag_in;
   logic                         flag_ff, flag_in;
   logic                         rsp_vld_ff, rsp_vld_in;
   logic [ptt_pkg::RSP_W-1:0]    rsp_data_ff;

   logic                         issue_ok;
   logic                         ev_act;
   logic [ptt_pkg::WORD_W-1:0]   rd_word;
   logic [TW-1:0]                rd_period;
   logic [TW-1:0]                rd_last;
   logic                         rd_exp;
   logic [TW-1:0]                elapsed;
   logic                         due;
   logic                         scan_wr;
   logic                         place_wr;
   logic                         room;
   logic                         wr_en;
   logic [AW-1:0]                wr_addr;
   logic [ptt_pkg::WORD_W-1:0]   wr_data;
   logic [CW+ptt_pkg::USED_W-1:0] used_wide;
   logic                         out_free;

   assign rd_period = rd_word[TW-1:0];
   assign rd_last   = rd_word[2*TW-1:TW];
   assign rd_exp    = rd_word[2*TW];
   assign elapsed   = now_ff - rd_last;
   assign due       = elapsed >= rd_period;
   assign room      = count_ff < CW'(ENTRIES);

   assign issue_ok  = cmd.walk && !hit_ff && (iss_ff < count_ff);
   assign ev_act    = cmd.walk && ev_vld_ff && !hit_ff;
   assign scan_wr   = ev_act && (op_ff == ptt_pkg::OP_SCAN);
   assign place_wr  = cmd.place && !hit_ff && room;

   always_comb begin
      wr_en   = scan_wr || place_wr;
      wr_addr = ev_idx_ff;
      wr_data = {due, (due ? now_ff : rd_last), rd_period};
      if (place_wr) begin
         wr_addr = count_ff[AW-1:0];
         wr_data = {1'b0, now_ff, per_ff};
      end
   end

   ptt_ram #(
      .WIDTH (ptt_pkg::WORD_W),
      .DEPTH (ENTRIES)
   ) u_ptt_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (issue_ok),
      .rd_addr (iss_ff[AW-1:0]),
      .rd_data (rd_word)
   );

   always_comb begin
      now_in      = now_ff;
      count_in    = count_ff;
      err_in      = err_ff;
      iss_in      = iss_ff;
      ev_vld_in   = issue_ok;
      hit_in      = hit_ff;
      hit_flag_in = hit_flag_ff;
      flag_in     = flag_ff;
      if (cmd.accept) begin
         flag_in = 1'b0;
      end
      if (cmd.tick) begin
         now_in = now_ff + TW'(1);
      end
      if (cmd.set_invalid) begin
         err_in[ptt_pkg::ERR_INVALID] = 1'b1;
      end
      if (cmd.walk_start) begin
         iss_in = '0;
         hit_in = 1'b0;
      end
      if (issue_ok) begin
         iss_in = iss_ff + CW'(1);
      end
      if (ev_act && (op_ff == ptt_pkg::OP_CHECK) && (rd_period == per_ff)) begin
         hit_in      = 1'b1;
         hit_flag_in = rd_exp;
      end
      if (cmd.place) begin
         if (hit_ff) begin
            flag_in = hit_flag_ff;
         end else if (room) begin
            count_in = count_ff + CW'(1);
         end else begin
            err_in[ptt_pkg::ERR_FULL] = 1'b1;
         end
      end
   end

   assign out_free   = !rsp_vld_ff || rsp_tready;
   assign rsp_vld_in = cmd.load_out ? 1'b1 : (rsp_tready ? 1'b0 : rsp_vld_ff);
   assign used_wide  = {{ptt_pkg::USED_W{1'b0}}, count_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         now_ff     <= '0;
         count_ff   <= '0;
         err_ff     <= '0;
         iss_ff     <= '0;
         ev_vld_ff  <= 1'b0;
         hit_ff     <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         now_ff     <= now_in;
         count_ff   <= count_in;
         err_ff     <= err_in;
         iss_ff     <= iss_in;
         ev_vld_ff  <= ev_vld_in;
         hit_ff     <= hit_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff  <= req_tdata[ptt_pkg::CMD_W-1:0];
         per_ff <= req_tdata[ptt_pkg::CMD_W+TW-1:ptt_pkg::CMD_W];
      end
      if (issue_ok) begin
         ev_idx_ff <= iss_ff[AW-1:0];
      end
      hit_flag_ff <= hit_flag_in;
      flag_ff     <= flag_in;
      if (cmd.load_out) begin
         rsp_data_ff <= {err_ff, used_wide[ptt_pkg::USED_W-1:0], flag_ff};
      end
   end

   assign sts.op         = op_ff;
   assign sts.period_bad = (per_ff == ptt_pkg::PERIOD_ZERO) || (per_ff == ptt_pkg::PERIOD_ONES);
   assign sts.walk_done  = hit_ff || (!(iss_ff < count_ff) && !ev_vld_ff);
   assign sts.out_free   = out_free;

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ----- rtl/core/ptt_checker.sv -----
`timescale 1ns / 1ps

module ptt_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_tvalid,
   input logic                      req_tready,
   input logic                      rsp_tvalid,
   input logic                      rsp_tready,
   input logic [ptt_pkg::RSP_W-1:0] rsp_tdata
);

   logic [ptt_pkg::ERR_W-1:0]  last_err_ff;
   logic [ptt_pkg::USED_W-1:0] last_used_ff;
   logic [ptt_pkg::ERR_W-1:0]  rsp_err;
   logic [ptt_pkg::USED_W-1:0] rsp_used;
   logic                       req_seen;

   assign rsp_err  = rsp_tdata[ptt_pkg::RSP_W-1:ptt_pkg::RSP_W-ptt_pkg::ERR_W];
   assign rsp_used = rsp_tdata[ptt_pkg::USED_W:1];
   assign req_seen = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         last_err_ff  <= '0;
         last_used_ff <= '0;
      end else if (rsp_tvalid && rsp_tready) begin
         last_err_ff  <= rsp_err;
         last_used_ff <= rsp_used;
      end
   end

   // stalled response holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response dropped or changed");

   // no response out of reset
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("response valid straight after reset");

   // error bits never clear
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((rsp_err & last_err_ff) == last_err_ff))
      else $error("sticky error bit cleared");

   // fill count grows by at most one per request
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_used == last_used_ff) ||
                     (rsp_used == last_used_ff + ptt_pkg::USED_W'(1)))
      else $error("used count jumped");

   // one request in flight: no request taken in the cycle after one
   assert property (@(posedge clock) disable iff (reset)
      req_seen |=> !req_tready)
      else $error("request accepted back to back");

endmodule

bind periodic_timer_table ptt_checker u_ptt_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
